>>> rtl/u2a_pkg.sv
// Shared types, constants and helpers for the unsigned-to-ASCII digit converter.
// No dependencies.
package u2a_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] FMT_DEC    = 8'h75;  // 'u'
  localparam logic [CHAR_W-1:0] FMT_HEX_LO = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] FMT_HEX_UP = 8'h58;  // 'X'

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  typedef enum logic [1:0] {
    MODE_DEC,
    MODE_HEX_LO,
    MODE_HEX_UP,
    MODE_INVALID
  } mode_e;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CHAR_ZERO + {4'h0, d};
    end else begin
      res = (upper ? CHAR_UP_A : CHAR_LO_A) + {4'h0, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

>>> rtl/u2a_if.sv
// Valid/ready channel interfaces for the converter's input and output.
// Depends on u2a_pkg.
interface u2a_in_if;
  logic                          valid;
  logic                          ready;
  logic [u2a_pkg::VALUE_W-1:0]   value;
  logic [u2a_pkg::CHAR_W-1:0]    format_char;

  modport source (output valid, output value, output format_char, input ready);
  modport sink   (input valid, input value, input format_char, output ready);
endinterface

interface u2a_out_if;
  logic                          valid;
  logic                          ready;
  logic [u2a_pkg::CHAR_W-1:0]    digit_char;
  logic                          last;
  logic                          invalid;

  modport source (output valid, output digit_char, output last, output invalid, input ready);
  modport sink   (input valid, input digit_char, input last, input invalid, output ready);
endinterface

>>> rtl/u2a_front.sv
// Front end: accepts input transactions, decodes the format letter, masks the value.
// Depends on u2a_pkg and u2a_if.
module u2a_front #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  u2a_in_if.sink                  in_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output u2a_pkg::mode_e          push_mode_o,
  output logic [VALUE_BITS-1:0]   push_value_o
);
  import u2a_pkg::*;

  logic                  vld_q;
  mode_e                 mode_q, mode_d;
  logic [VALUE_BITS-1:0] val_q;

  assign in_i.ready = !vld_q || push_ready_i;

  always_comb begin
    priority if (in_i.format_char == FMT_DEC) begin
      mode_d = MODE_DEC;
    end else if (in_i.format_char == FMT_HEX_LO) begin
      mode_d = MODE_HEX_LO;
    end else if (in_i.format_char == FMT_HEX_UP) begin
      mode_d = MODE_HEX_UP;
    end else begin
      mode_d = MODE_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= mode_d;
      val_q  <= in_i.value[VALUE_BITS-1:0];
    end
  end

  assign push_valid_o = vld_q;
  assign push_mode_o  = mode_q;
  assign push_value_o = val_q;

endmodule

>>> rtl/u2a_fifo.sv
// Small synchronous queue between the front end and the digit engine.
// No package dependencies.
module u2a_fifo #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/u2a_back.sv
// Digit engine: serial BCD for decimal, then one digit per cycle unless stalled.
// Depends on u2a_pkg and u2a_if.
module u2a_back #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned NDIG       = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_o,
  input  u2a_pkg::mode_e          pop_mode_i,
  input  logic [VALUE_BITS-1:0]   pop_value_i,
  u2a_out_if.source               out_o
);
  import u2a_pkg::*;

  localparam int unsigned DW    = NDIG * 4;
  localparam int unsigned BIT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIG_W = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_INV
  } state_e;

  state_e              state_q;
  logic [VALUE_BITS-1:0] bin_q;
  logic [DW-1:0]       dig_q;
  logic [DW-1:0]       adj;
  logic                upper_q;
  logic [BIT_W-1:0]    bits_q;
  logic [DIG_W-1:0]    left_q;
  logic                seen_q;
  logic                out_vld_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q, inv_q;
  logic                out_free;
  logic [3:0]          top_nib;
  logic                fin;
  logic                emit;

  assign out_free = !out_vld_q || out_o.ready;
  assign pop_o    = (state_q == ST_IDLE) && pop_valid_i;
  assign top_nib  = dig_q[DW-1 -: 4];
  assign fin      = (left_q == DIG_W'(1));
  assign emit     = out_free &&
                    (((state_q == ST_EMIT) && (seen_q || top_nib != 4'h0 || fin)) ||
                     (state_q == ST_INV));

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3 : dig_q[i*4 +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      bits_q    <= '0;
      left_q    <= '0;
      seen_q    <= 1'b0;
      upper_q   <= 1'b0;
      char_q    <= CHAR_NONE;
      last_q    <= 1'b0;
      inv_q     <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            unique case (pop_mode_i)
              MODE_DEC: begin
                bits_q  <= BIT_W'(VALUE_BITS);
                upper_q <= 1'b0;
                state_q <= ST_CONV;
              end
              MODE_HEX_LO, MODE_HEX_UP: begin
                upper_q <= (pop_mode_i == MODE_HEX_UP);
                left_q  <= DIG_W'(NDIG);
                seen_q  <= 1'b0;
                state_q <= ST_EMIT;
              end
              default: state_q <= ST_INV;
            endcase
          end
        end
        ST_CONV: begin
          bits_q <= bits_q - 1'b1;
          if (bits_q == BIT_W'(1)) begin
            left_q  <= DIG_W'(NDIG);
            seen_q  <= 1'b0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (seen_q || top_nib != 4'h0 || fin) begin
              seen_q <= 1'b1;
            end
            char_q <= digit_to_ascii(top_nib, upper_q);
            last_q <= fin;
            inv_q  <= 1'b0;
            left_q <= left_q - 1'b1;
            if (fin) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_INV: begin
          if (out_free) begin
            char_q  <= CHAR_NONE;
            last_q  <= 1'b1;
            inv_q   <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          bin_q <= pop_value_i;
          if (pop_mode_i == MODE_DEC) begin
            dig_q <= '0;
          end else begin
            dig_q <= DW'(pop_value_i);
          end
        end
      end
      ST_CONV: begin
        dig_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
        bin_q <= bin_q << 1;
      end
      ST_EMIT: begin
        if (out_free) begin
          dig_q <= {dig_q[DW-5:0], 4'h0};
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.digit_char = char_q;
  assign out_o.last       = last_q;
  assign out_o.invalid    = inv_q;

endmodule

>>> rtl/unsigned_to_ascii_digits.sv
// Top level of the unsigned-to-ASCII digit converter.
// Depends on u2a_pkg, u2a_if, u2a_front, u2a_fifo and u2a_back.
//
// Converts the low VALUE_BITS bits of an unsigned value to ASCII digits, most
// significant first, one character per output transaction with last on the
// final one: 'u' decimal, 'x' lowercase hex, 'X' uppercase hex. Zero gives "0";
// any other format letter gives a single NUL character with invalid and last set.
// An item is handled one at a time by the digit engine: it is taken from the
// queue in the idle state, then for decimal it goes through bit-serial
// shift-and-add-3 conversion and a digit scan over NDIG positions, for hex
// through the digit scan alone, and for an invalid letter it yields a single
// invalid character, where NDIG is the decimal width of the largest value.
// The digit scan takes one digit position per cycle, leading zeros included,
// and stalls while the output register is held. The input register and a
// two-entry queue keep accepting items while the engine is busy.
module unsigned_to_ascii_digits #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2a_in_if.sink     in_i,
  u2a_out_if.source  out_o
);
  import u2a_pkg::*;

  localparam int unsigned NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned Q_W    = VALUE_BITS + 2;

  logic                  push_valid, push_ready, fifo_full, fifo_empty, pop;
  mode_e                 push_mode, pop_mode;
  logic [VALUE_BITS-1:0] push_value, pop_value;
  logic [Q_W-1:0]        pop_data;

  assign push_ready = !fifo_full;

  u2a_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_mode_o  (push_mode),
    .push_value_o (push_value)
  );

  u2a_fifo #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i ({push_mode, push_value}),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (fifo_empty)
  );

  assign pop_mode  = mode_e'(pop_data[Q_W-1 -: 2]);
  assign pop_value = pop_data[VALUE_BITS-1:0];

  u2a_back #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (!fifo_empty),
    .pop_o       (pop),
    .pop_mode_i  (pop_mode),
    .pop_value_i (pop_value),
    .out_o       (out_o)
  );

endmodule

>>> test/tb.sv
// Self-checking bench for unsigned_to_ascii_digits: random and directed values and format
// letters are driven over the input channel and each output digit is checked against a predictor.
// Depends on u2a_pkg, u2a_if and the RTL of the converter.
module tb;
  import u2a_pkg::*;

  localparam int unsigned VALUE_BITS  = 64;
  localparam int          MAX_DIGITS  = 20;
  localparam int          RAND_PER_PH = 39;
  localparam int          HOLD_AT     = 30;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN       = 200;
  localparam int          LIMIT       = 500000;
  localparam logic [63:0] VALUE_MASK  =
    (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CHAR_W-1:0]  format_char;
  } num_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              invalid;
  } digit_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  u2a_in_if  in_if ();
  u2a_out_if out_if ();

  unsigned_to_ascii_digits #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  num_item_t num_queue[$];
  digit_t    digit_queue[$];

  int num_issued   = 0;
  int num_accepted = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  logic in_fire    = 1'b0;

  // Expected characters for one value/format pair, most significant first.
  function automatic void predict_digits(logic [63:0] value, logic [7:0] fmt);
    string       tbl;
    logic [63:0] v;
    logic [63:0] base;
    logic [7:0]  rev [MAX_DIGITS];
    int          n;
    int          k;
    digit_t      d;
    v = value & VALUE_MASK;
    n = 0;
    if (fmt == FMT_DEC) begin
      tbl  = "0123456789";
      base = 64'd10;
    end else if (fmt == FMT_HEX_LO) begin
      tbl  = "0123456789abcdef";
      base = 64'd16;
    end else if (fmt == FMT_HEX_UP) begin
      tbl  = "0123456789ABCDEF";
      base = 64'd16;
    end else begin
      d.digit_char = CHAR_NONE;
      d.last       = 1'b1;
      d.invalid    = 1'b1;
      digit_queue.push_back(d);
      return;
    end
    do begin
      rev[n] = tbl[int'(v % base)];
      v = v / base;
      n++;
    end while (v != 64'd0 && n < MAX_DIGITS);
    for (k = n - 1; k >= 0; k--) begin
      d.digit_char = rev[k];
      d.last       = (k == 0);
      d.invalid    = 1'b0;
      digit_queue.push_back(d);
    end
  endfunction

  task automatic add_item(logic [63:0] value, logic [7:0] fmt);
    num_item_t it;
    it.value       = value;
    it.format_char = fmt;
    num_queue.push_back(it);
    num_issued++;
  endtask

  // Driver: inputs change on the falling edge; valid holds until the transaction completes.
  always @(negedge clk_i) begin
    num_item_t it;
    if (!in_if.valid || in_fire) begin
      if (num_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = num_queue.pop_front();
        in_if.valid       <= 1'b1;
        in_if.value       <= it.value;
        in_if.format_char <= it.format_char;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  // Long receiver hold-off while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rst_ni && num_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: predict on input transactions, check output transactions.
  always @(posedge clk_i) begin
    digit_t got;
    digit_t want;
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_digits(in_if.value, in_if.format_char);
        num_accepted <= num_accepted + 1;
      end
      if (out_if.valid && out_if.ready) begin
        got.digit_char = out_if.digit_char;
        got.last       = out_if.last;
        got.invalid    = out_if.invalid;
        if (digit_queue.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("tb: unexpected digit %h last %b invalid %b",
                     got.digit_char, got.last, got.invalid);
        end else begin
          want = digit_queue.pop_front();
          if (got.digit_char !== want.digit_char || got.last !== want.last ||
              got.invalid !== want.invalid) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("tb: mismatch want %h/%b/%b got %h/%b/%b",
                       want.digit_char, want.last, want.invalid,
                       got.digit_char, got.last, got.invalid);
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int          ph;
    int          i;
    int          w;
    logic [63:0] v;
    logic [7:0]  fmt;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.value       = '0;
    in_if.format_char = '0;
    out_if.ready      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_item(64'd0, FMT_DEC);
    add_item(64'd0, FMT_HEX_LO);
    add_item(64'd0, FMT_HEX_UP);
    add_item({64{1'b1}}, FMT_DEC);
    add_item({64{1'b1}}, FMT_HEX_LO);
    add_item({64{1'b1}}, FMT_HEX_UP);
    add_item(64'd1, FMT_DEC);
    add_item(64'd9, FMT_DEC);
    add_item(64'd10, FMT_DEC);
    add_item(64'd15, FMT_HEX_LO);
    add_item(64'd16, FMT_HEX_UP);
    add_item(64'd9999999999999999999, FMT_DEC);
    add_item(64'd10000000000000000000, FMT_DEC);
    add_item(64'hFEDC_BA98_7654_3210, FMT_HEX_UP);
    add_item(64'hABCD_EF01_2345_6789, FMT_HEX_LO);
    add_item(64'hFFFF_FFFF, FMT_DEC);
    add_item(64'd1234, 8'h00);
    add_item(64'd1234, 8'hFF);
    add_item(64'd0, 8'h55);
    add_item({64{1'b1}}, 8'h74);
    add_item(64'd42, 8'h76);
    add_item(64'd42, 8'h79);
    add_item(64'd42, 8'h59);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 75; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
        default: begin src_idle_pct = 18; snk_stall_pct = 18; end
      endcase
      for (i = 0; i < RAND_PER_PH; i++) begin
        v = {$urandom, $urandom};
        w = $urandom_range(64, 1);
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        if ($urandom_range(99) < 80) begin
          case ($urandom_range(2))
            0: fmt = FMT_DEC;
            1: fmt = FMT_HEX_LO;
            default: fmt = FMT_HEX_UP;
          endcase
        end else begin
          fmt = 8'($urandom_range(255));
        end
        add_item(v, fmt);
      end
      do @(negedge clk_i); while (num_accepted != num_issued);
      @(posedge clk_i);
    end

    do @(negedge clk_i); while (digit_queue.size() != 0);
    repeat (DRAIN) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/u2a_pkg.sv
rtl/u2a_if.sv
rtl/u2a_front.sv
rtl/u2a_fifo.sv
rtl/u2a_back.sv
rtl/unsigned_to_ascii_digits.sv
test/tb.sv
